// ----- hdl/bbc_lru_pkg.sv -----
package bbc_lru_pkg;

  // Cache geometry
  localparam int ENTRIES     = 512;
  localparam int HOLDER_BITS = 8;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam logic [HOLDER_BITS-1:0] HOLDER_MAX = {HOLDER_BITS{1'b1}};

  // Command codes
  localparam logic [2:0] CMD_GET        = 3'd0;
  localparam logic [2:0] CMD_RELEASE    = 3'd1;
  localparam logic [2:0] CMD_READ_DONE  = 3'd2;
  localparam logic [2:0] CMD_WRITE_DONE = 3'd3;
  localparam logic [2:0] CMD_MARK_DIRTY = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  device_id;
    logic [31:0] block_num;
    logic [8:0]  entry_index;
    logic        read_ok;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [8:0]  result_entry;
    logic        was_hit;
    logic        need_read;
    logic        need_writeback;
    logic [7:0]  evict_device;
    logic [31:0] evict_block;
  } out_word_t;

  // One cache entry as held in the tag memory
  typedef struct packed {
    logic [7:0]             tag_device;
    logic [31:0]            tag_block;
    logic [HOLDER_BITS-1:0] holders;
    logic                   valid_mark;
    logic                   dirty_mark;
    logic [IDX_W-1:0]       rank;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RMW,
    ST_RESULT
  } state_t;

endpackage

// ----- hdl/block_buffer_cache_lru_unit.sv -----
// Tag and LRU replacement manager for a block buffer cache of
// bbc_lru_pkg::ENTRIES entries, all kept in one entry memory (one read and
// one write port, registered read). After reset a clearing pass writes every
// entry before the first word is taken. For a get, one sweep of the memory
// finds the hit or the least recently used free entry; if either is found,
// a second read-modify-write sweep updates the recency ranks and the claimed
// entry. Release, read done, write done and mark dirty with an index inside
// the cache do one memory read-modify-write; other commands skip the memory.
// One word is worked on at a time; a finished result sits in the output
// register while the next word enters.
module block_buffer_cache_lru_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bbc_lru_pkg::in_word_t in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bbc_lru_pkg::out_word_t out_word
);

  localparam int IW = bbc_lru_pkg::IDX_W;
  localparam int CW = bbc_lru_pkg::CNT_W;
  localparam int HB = bbc_lru_pkg::HOLDER_BITS;
  localparam logic [CW-1:0] CNT_END  = CW'(bbc_lru_pkg::ENTRIES);
  localparam logic [IW-1:0] IDX_LAST = IW'(bbc_lru_pkg::ENTRIES - 1);

  // Entry memory
  bbc_lru_pkg::entry_t mem [bbc_lru_pkg::ENTRIES];
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  bbc_lru_pkg::entry_t mem_wdata;
  bbc_lru_pkg::entry_t rd_data_r;
  logic [IW-1:0]       rd_idx_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
    rd_idx_r <= mem_raddr;
  end

  // Control and working registers
  bbc_lru_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  bbc_lru_pkg::in_word_t  cmd_r, cmd_nxt;
  logic                   found_r, found_nxt;
  logic [IW-1:0]          hit_idx_r, hit_idx_nxt;
  bbc_lru_pkg::entry_t    hit_ent_r, hit_ent_nxt;
  logic                   have_r, have_nxt;
  logic [IW-1:0]          best_idx_r, best_idx_nxt;
  bbc_lru_pkg::entry_t    best_ent_r, best_ent_nxt;
  logic [IW-1:0]          tgt_idx_r, tgt_idx_nxt;
  logic [IW-1:0]          tgt_rank_r, tgt_rank_nxt;
  logic                   tgt_miss_r, tgt_miss_nxt;
  bbc_lru_pkg::out_word_t res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bbc_lru_pkg::out_word_t out_word_r, out_word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbc_lru_pkg::ST_INIT;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= mem_re;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      have_r      <= have_nxt;
    end
    cmd_r      <= cmd_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    best_idx_r <= best_idx_nxt;
    best_ent_r <= best_ent_nxt;
    tgt_idx_r  <= tgt_idx_nxt;
    tgt_rank_r <= tgt_rank_nxt;
    tgt_miss_r <= tgt_miss_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_ready  = (state_r == bbc_lru_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Next state, memory control and result
  always_comb begin
    bbc_lru_pkg::entry_t w;
    logic                in_range;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_ent_nxt  = best_ent_r;
    tgt_idx_nxt   = tgt_idx_r;
    tgt_rank_nxt  = tgt_rank_r;
    tgt_miss_nxt  = tgt_miss_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = rd_idx_r;
    mem_raddr     = cnt_r[IW-1:0];
    w             = rd_data_r;
    mem_wdata     = w;
    in_range      = (32'(cmd_r.entry_index) < 32'(bbc_lru_pkg::ENTRIES));

    unique case (state_r)
      // clearing pass: zero tags and marks, rank = own index
      bbc_lru_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[IW-1:0];
        mem_wdata = '0;
        mem_wdata.rank = cnt_r[IW-1:0];
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r[IW-1:0] == IDX_LAST) begin
          state_nxt = bbc_lru_pkg::ST_IDLE;
        end
      end

      bbc_lru_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_word;
          res_nxt   = '0;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          have_nxt  = 1'b0;
          if (in_word.cmd == bbc_lru_pkg::CMD_GET) begin
            state_nxt = bbc_lru_pkg::ST_SCAN;
          end else if ((32'(in_word.entry_index) < 32'(bbc_lru_pkg::ENTRIES)) &&
                       (in_word.cmd == bbc_lru_pkg::CMD_RELEASE ||
                        in_word.cmd == bbc_lru_pkg::CMD_READ_DONE ||
                        in_word.cmd == bbc_lru_pkg::CMD_WRITE_DONE ||
                        in_word.cmd == bbc_lru_pkg::CMD_MARK_DIRTY)) begin
            mem_re    = 1'b1;
            mem_raddr = IW'(in_word.entry_index);
            state_nxt = bbc_lru_pkg::ST_RMW;
          end else begin
            state_nxt = bbc_lru_pkg::ST_RESULT;
          end
        end
      end

      // sweep: lowest held tag match, and oldest free entry
      bbc_lru_pkg::ST_SCAN: begin
        if (cnt_r != CNT_END) begin
          mem_re  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (!found_r && w.holders != '0 && w.tag_device == cmd_r.device_id &&
              w.tag_block == cmd_r.block_num) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = rd_idx_r;
            hit_ent_nxt = w;
          end
          if (w.holders == '0 && (!have_r || w.rank > best_ent_r.rank)) begin
            have_nxt     = 1'b1;
            best_idx_nxt = rd_idx_r;
            best_ent_nxt = w;
          end
          if (rd_idx_r == IDX_LAST) begin
            state_nxt = bbc_lru_pkg::ST_DECIDE;
          end
        end
      end

      bbc_lru_pkg::ST_DECIDE: begin
        cnt_nxt = '0;
        if (found_r) begin
          tgt_idx_nxt          = hit_idx_r;
          tgt_rank_nxt         = hit_ent_r.rank;
          tgt_miss_nxt         = 1'b0;
          res_nxt.result_entry = 9'(hit_idx_r);
          res_nxt.was_hit      = 1'b1;
          res_nxt.need_read    = ~hit_ent_r.valid_mark;
          state_nxt            = bbc_lru_pkg::ST_UPDATE;
        end else if (have_r) begin
          tgt_idx_nxt          = best_idx_r;
          tgt_rank_nxt         = best_ent_r.rank;
          tgt_miss_nxt         = 1'b1;
          res_nxt.result_entry = 9'(best_idx_r);
          res_nxt.need_read    = 1'b1;
          if (best_ent_r.dirty_mark) begin
            res_nxt.need_writeback = 1'b1;
            res_nxt.evict_device   = best_ent_r.tag_device;
            res_nxt.evict_block    = best_ent_r.tag_block;
          end
          state_nxt = bbc_lru_pkg::ST_UPDATE;
        end else begin
          res_nxt.status = 1'b1;
          state_nxt      = bbc_lru_pkg::ST_RESULT;
        end
      end

      // read-modify-write sweep: age newer entries, promote the target
      bbc_lru_pkg::ST_UPDATE: begin
        if (cnt_r != CNT_END) begin
          mem_re  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (rd_idx_r == tgt_idx_r) begin
            w.rank = '0;
            if (tgt_miss_r) begin
              w.tag_device = cmd_r.device_id;
              w.tag_block  = cmd_r.block_num;
              w.holders    = HB'(1);
              w.valid_mark = 1'b0;
              w.dirty_mark = 1'b0;
            end else if (w.holders != bbc_lru_pkg::HOLDER_MAX) begin
              w.holders = w.holders + HB'(1);
            end
          end else if (w.rank < tgt_rank_r) begin
            w.rank = w.rank + IW'(1);
          end
          mem_we    = 1'b1;
          mem_wdata = w;
          if (rd_idx_r == IDX_LAST) begin
            state_nxt = bbc_lru_pkg::ST_RESULT;
          end
        end
      end

      // single entry update for the non-get commands
      bbc_lru_pkg::ST_RMW: begin
        if (rd_vld_r) begin
          case (cmd_r.cmd)
            bbc_lru_pkg::CMD_RELEASE: begin
              if (w.holders != '0) w.holders = w.holders - HB'(1);
            end
            bbc_lru_pkg::CMD_READ_DONE: begin
              if (cmd_r.read_ok) begin
                w.valid_mark = 1'b1;
              end else if (w.holders != '0) begin
                w.holders = w.holders - HB'(1);
              end
            end
            bbc_lru_pkg::CMD_WRITE_DONE: w.dirty_mark = 1'b0;
            bbc_lru_pkg::CMD_MARK_DIRTY: w.dirty_mark = 1'b1;
            default: ;
          endcase
          mem_we    = in_range;
          mem_wdata = w;
          state_nxt = bbc_lru_pkg::ST_RESULT;
        end
      end

      bbc_lru_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = bbc_lru_pkg::ST_IDLE;
        end
      end

      default: state_nxt = bbc_lru_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NE = bbc_lru_pkg::ENTRIES;
  localparam int HB = bbc_lru_pkg::HOLDER_BITS;

  // Rows of the directed stimulus; chk_exp set where the result is typed in
  typedef struct {
    bbc_lru_pkg::in_word_t  w;
    logic                   chk_exp;
    bbc_lru_pkg::out_word_t exp;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  bbc_lru_pkg::in_word_t  in_word = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  bbc_lru_pkg::out_word_t out_word;

  // Shadow copy of the cache tags and replacement state
  logic [7:0]    sh_dev [NE];
  logic [31:0]   sh_blk [NE];
  logic [HB-1:0] sh_hold [NE];
  logic          sh_valid [NE];
  logic          sh_dirty [NE];
  int unsigned   sh_rank [NE];

  bbc_lru_pkg::out_word_t pending_results[$];
  int          err_cnt = 0;
  int          words_sent = 0;
  int          words_back = 0;
  int          hits_seen = 0;
  int          wb_seen = 0;
  int          full_seen = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;
  logic [31:0] blk_pool [8];

  block_buffer_cache_lru_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always #1 clk = ~clk;

  // Watchdog: each get sweeps the whole entry memory, plus stalls
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $display("timeout: sent %0d, returned %0d", words_sent, words_back);
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= 30)
      $display("mismatch at result %0d: %s got %0h expected %0h", words_back, what, got, want);
  endtask

  function automatic void cache_reset();
    for (int i = 0; i < NE; i++) begin
      sh_dev[i] = '0;
      sh_blk[i] = '0;
      sh_hold[i] = '0;
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_rank[i] = i;
    end
  endfunction

  function automatic void promote_entry(input int e);
    int unsigned r;
    r = sh_rank[e];
    for (int j = 0; j < NE; j++)
      if (sh_rank[j] < r) sh_rank[j]++;
    sh_rank[e] = 0;
  endfunction

  // Works out one result and advances the shadow state
  function automatic bbc_lru_pkg::out_word_t cache_lookup(input bbc_lru_pkg::in_word_t w);
    bbc_lru_pkg::out_word_t r;
    int e;
    int best;
    r = '0;
    if (w.cmd == bbc_lru_pkg::CMD_GET) begin
      e = -1;
      for (int i = 0; i < NE; i++)
        if (e < 0 && sh_hold[i] != 0 && sh_dev[i] == w.device_id && sh_blk[i] == w.block_num)
          e = i;
      if (e >= 0) begin
        if (sh_hold[e] != bbc_lru_pkg::HOLDER_MAX) sh_hold[e]++;
        promote_entry(e);
        r.result_entry = 9'(e);
        r.was_hit = 1'b1;
        r.need_read = !sh_valid[e];
        return r;
      end
      best = -1;
      for (int i = 0; i < NE; i++)
        if (sh_hold[i] == 0 && (best < 0 || sh_rank[i] > sh_rank[best])) best = i;
      if (best < 0) begin
        r.status = 1'b1;
        return r;
      end
      if (sh_dirty[best]) begin
        r.need_writeback = 1'b1;
        r.evict_device = sh_dev[best];
        r.evict_block = sh_blk[best];
      end
      sh_dev[best] = w.device_id;
      sh_blk[best] = w.block_num;
      sh_hold[best] = HB'(1);
      sh_valid[best] = 1'b0;
      sh_dirty[best] = 1'b0;
      promote_entry(best);
      r.result_entry = 9'(best);
      r.need_read = 1'b1;
      return r;
    end
    if (w.entry_index >= NE) return r;
    case (w.cmd)
      bbc_lru_pkg::CMD_RELEASE: if (sh_hold[w.entry_index] != 0) sh_hold[w.entry_index]--;
      bbc_lru_pkg::CMD_READ_DONE: begin
        if (w.read_ok) sh_valid[w.entry_index] = 1'b1;
        else if (sh_hold[w.entry_index] != 0) sh_hold[w.entry_index]--;
      end
      bbc_lru_pkg::CMD_WRITE_DONE: sh_dirty[w.entry_index] = 1'b0;
      bbc_lru_pkg::CMD_MARK_DIRTY: sh_dirty[w.entry_index] = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // Sender: one word, holding valid until taken
  task automatic send_word(input bbc_lru_pkg::in_word_t w, input logic chk_exp = 1'b0,
                           input bbc_lru_pkg::out_word_t exp = '0);
    bbc_lru_pkg::out_word_t p;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = cache_lookup(w);
    if (chk_exp && p !== exp) report_mismatch("typed-in result", 64'(p), 64'(exp));
    pending_results.push_back(p);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic bbc_lru_pkg::in_word_t rand_cmd_word(input int n_busy);
    bbc_lru_pkg::in_word_t w;
    int k;
    w = '0;
    w.device_id = 8'($urandom_range(3));
    w.block_num = blk_pool[$urandom_range(7)];
    w.entry_index = 9'($urandom_range(n_busy - 1));
    w.read_ok = 1'($urandom_range(1));
    k = $urandom_range(99);
    if (k < 40) w.cmd = bbc_lru_pkg::CMD_GET;
    else if (k < 62) w.cmd = bbc_lru_pkg::CMD_RELEASE;
    else if (k < 76) w.cmd = bbc_lru_pkg::CMD_READ_DONE;
    else if (k < 84) w.cmd = bbc_lru_pkg::CMD_WRITE_DONE;
    else if (k < 94) w.cmd = bbc_lru_pkg::CMD_MARK_DIRTY;
    else begin
      // noise: wide fields, unused commands, indexes past the cache
      w = bbc_lru_pkg::in_word_t'($bits(bbc_lru_pkg::in_word_t)'({$urandom, $urandom}));
    end
    return w;
  endfunction

  // Result side: stalls, compare against oldest expectation
  initial begin
    bbc_lru_pkg::out_word_t e;
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      @(posedge clk);
      if (out_valid && out_ready) begin
        words_back++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_word), 64'(0));
        end else begin
          e = pending_results.pop_front();
          if (out_word.status !== e.status)
            report_mismatch("status", 64'(out_word.status), 64'(e.status));
          if (out_word.result_entry !== e.result_entry)
            report_mismatch("result_entry", 64'(out_word.result_entry), 64'(e.result_entry));
          if (out_word.was_hit !== e.was_hit)
            report_mismatch("was_hit", 64'(out_word.was_hit), 64'(e.was_hit));
          if (out_word.need_read !== e.need_read)
            report_mismatch("need_read", 64'(out_word.need_read), 64'(e.need_read));
          if (out_word.need_writeback !== e.need_writeback)
            report_mismatch("need_writeback", 64'(out_word.need_writeback),
                            64'(e.need_writeback));
          if (out_word.evict_device !== e.evict_device)
            report_mismatch("evict_device", 64'(out_word.evict_device), 64'(e.evict_device));
          if (out_word.evict_block !== e.evict_block)
            report_mismatch("evict_block", 64'(out_word.evict_block), 64'(e.evict_block));
          if (e.was_hit) hits_seen++;
          if (e.need_writeback) wb_seen++;
          if (e.status) full_seen++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t rows[$];
    bbc_lru_pkg::in_word_t w;
    bbc_lru_pkg::out_word_t x;
    int phase_pct [4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{22, 22}};
    cache_reset();
    for (int i = 0; i < 8; i++) blk_pool[i] = (i == 7) ? 32'hFFFF_FFFF : $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first get after reset claims the least recent entry
    x = '0; x.result_entry = 9'(NE - 1); x.need_read = 1'b1;
    rows.push_back('{'{bbc_lru_pkg::CMD_GET, 8'hFF, 32'hFFFF_FFFF, 9'd0, 1'b0}, 1'b1, x});
    x = '0; x.result_entry = 9'(NE - 1); x.was_hit = 1'b1; x.need_read = 1'b1;
    rows.push_back('{'{bbc_lru_pkg::CMD_GET, 8'hFF, 32'hFFFF_FFFF, 9'd0, 1'b0}, 1'b1, x});
    rows.push_back('{'{bbc_lru_pkg::CMD_READ_DONE, 8'h0, 32'h0, 9'd511, 1'b1}, 1'b1, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_GET, 8'hFF, 32'hFFFF_FFFF, 9'd0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_MARK_DIRTY, 8'h0, 32'h0, 9'd511, 1'b0}, 1'b1, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_RELEASE, 8'h0, 32'h0, 9'd511, 1'b0}, 1'b1, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_RELEASE, 8'h0, 32'h0, 9'd511, 1'b0}, 1'b1, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_RELEASE, 8'h0, 32'h0, 9'd511, 1'b0}, 1'b1, '0});
    // tag matches but unheld: no hit
    rows.push_back('{'{bbc_lru_pkg::CMD_GET, 8'hFF, 32'hFFFF_FFFF, 9'd0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_GET, 8'h00, 32'h0, 9'd0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_READ_DONE, 8'h0, 32'h0, 9'd510, 1'b0}, 1'b0, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_READ_DONE, 8'h0, 32'h0, 9'd510, 1'b0}, 1'b0, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_WRITE_DONE, 8'h0, 32'h0, 9'd0, 1'b1}, 1'b1, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_MARK_DIRTY, 8'h0, 32'h0, 9'd0, 1'b0}, 1'b1, '0});
    // unused commands
    rows.push_back('{'{3'd5, 8'hFF, 32'hFFFF_FFFF, 9'd511, 1'b1}, 1'b1, '0});
    rows.push_back('{'{3'd6, 8'h55, 32'hAAAA_5555, 9'd3, 1'b0}, 1'b1, '0});
    rows.push_back('{'{3'd7, 8'hAA, 32'h5555_AAAA, 9'd0, 1'b1}, 1'b1, '0});
    // least recent free entry recycled dirty: write-back of its old tag
    rows.push_back('{'{bbc_lru_pkg::CMD_MARK_DIRTY, 8'h0, 32'h0, 9'd508, 1'b0}, 1'b0, '0});
    rows.push_back('{'{bbc_lru_pkg::CMD_GET, 8'h12, 32'h0000_0001, 9'd0, 1'b0}, 1'b0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].chk_exp, rows[i].exp);
    wait_drained();

    // Holder saturation on one entry
    w = '0; w.cmd = bbc_lru_pkg::CMD_GET; w.device_id = 8'h7E; w.block_num = 32'h8000_0000;
    for (int i = 0; i < 258; i++) send_word(w);
    wait_drained();

    // Exhaustion: hold every other entry, then one more get fails
    for (int i = 0; i < NE - 1; i++) begin
      w = '0; w.cmd = bbc_lru_pkg::CMD_GET; w.device_id = 8'h40;
      w.block_num = 32'(32'h1000 + i);
      send_word(w);
    end
    x = '0; x.status = 1'b1;
    w = '0; w.cmd = bbc_lru_pkg::CMD_GET; w.device_id = 8'h41; w.block_num = 32'h0;
    send_word(w, 1'b1, x);
    // long receiver hold-off while sender keeps going
    wait_drained();
    hold_off_cycles = 3000;
    for (int i = 0; i < 48; i++) begin
      w = '0; w.cmd = bbc_lru_pkg::CMD_RELEASE; w.entry_index = 9'(i);
      send_word(w);
      if (i % 2 == 0) send_word(w);
    end
    wait_drained();

    // Random phases on a small working set of entries and tags
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_pct[ph][0];
      recv_stall_pct = phase_pct[ph][1];
      for (int i = 0; i < 75; i++) send_word(rand_cmd_word(24));
      wait_drained();
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("%0d words sent, %0d results: %0d hits, %0d write-backs, %0d full-cache gets",
             words_sent, words_back, hits_seen, wb_seen, full_seen);
    $display("covered: reset state, saturation, full cache, long output stall, idle mixes");
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
